>>> rtl/core/c39_pkg.sv
`default_nettype none

package c39_pkg;

    // One input request: a single run of the scan row.
    typedef struct packed {
        logic [11:0] run_width;
        logic        row_end;
    } in_item_t;

    // One result request: a character or a failure code.
    typedef struct packed {
        logic [6:0] char_code;
        logic [3:0] status;
        logic       last;
    } out_item_t;

    localparam logic [3:0] STS_OK        = 4'd0;
    localparam logic [3:0] STS_FEW       = 4'd1;
    localparam logic [3:0] STS_UNIFORM   = 4'd2;
    localparam logic [3:0] STS_BAD_START = 4'd3;
    localparam logic [3:0] STS_WIDE_SEP  = 4'd4;
    localparam logic [3:0] STS_UNKNOWN   = 4'd5;
    localparam logic [3:0] STS_EMPTY     = 4'd6;
    localparam logic [3:0] STS_TOO_LONG  = 4'd7;
    localparam logic [3:0] STS_TRUNC     = 4'd8;
    localparam logic [3:0] STS_OVERFLOW  = 4'd9;

    localparam int         MIN_RUNS  = 19;
    localparam logic [8:0] STAR_PAT  = 9'h094;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_START,
        ST_START_WAIT,
        ST_NEXT,
        ST_STOP_WAIT,
        ST_DATA_WAIT,
        ST_ERR,
        ST_TXT_RD,
        ST_TXT_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       init;
        logic       gather_go;
        logic       gather10;
        logic       pos_add9;
        logic       pos_add10;
        logic       txt_wr;
        logic       err_latch;
        logic [3:0] err_code;
        logic       clr_row;
        logic       optr_clr;
        logic       out_err;
        logic       out_txt;
    } c39_cmd_t;

    typedef struct packed {
        logic row_ovf;
        logic row_few;
        logic row_uniform;
        logic rem9;
        logic rem_lt10;
        logic gather_done;
        logic sep_wide;
        logic pat_stop;
        logic pat_miss;
        logic tlen_zero;
        logic tlen_full;
        logic txt_last;
        logic out_free;
    } c39_stat_t;

    // Code 39 wide/narrow pattern to ASCII; zero when the pattern is not a symbol.
    function automatic logic [6:0] lookup(input logic [8:0] pat);
        logic [6:0] c;
        c = 7'h00;
        case (pat)
            9'h034: c = 7'h30;  9'h121: c = 7'h31;  9'h061: c = 7'h32;
            9'h160: c = 7'h33;  9'h031: c = 7'h34;  9'h130: c = 7'h35;
            9'h070: c = 7'h36;  9'h025: c = 7'h37;  9'h124: c = 7'h38;
            9'h064: c = 7'h39;
            9'h109: c = 7'h41;  9'h049: c = 7'h42;  9'h148: c = 7'h43;
            9'h019: c = 7'h44;  9'h118: c = 7'h45;  9'h058: c = 7'h46;
            9'h00D: c = 7'h47;  9'h10C: c = 7'h48;  9'h04C: c = 7'h49;
            9'h01C: c = 7'h4A;  9'h103: c = 7'h4B;  9'h043: c = 7'h4C;
            9'h142: c = 7'h4D;  9'h013: c = 7'h4E;  9'h112: c = 7'h4F;
            9'h052: c = 7'h50;  9'h007: c = 7'h51;  9'h106: c = 7'h52;
            9'h046: c = 7'h53;  9'h016: c = 7'h54;  9'h181: c = 7'h55;
            9'h0C1: c = 7'h56;  9'h1C0: c = 7'h57;  9'h091: c = 7'h58;
            9'h190: c = 7'h59;  9'h0D0: c = 7'h5A;
            9'h085: c = 7'h2D;  9'h184: c = 7'h2E;  9'h0C4: c = 7'h20;
            9'h0A8: c = 7'h24;  9'h0A2: c = 7'h2F;  9'h08A: c = 7'h2B;
            9'h082: c = 7'h25;  9'h094: c = 7'h2A;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/c39_ctrl.sv
`default_nettype none

module c39_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_row_end,
    input  wire c39_pkg::c39_stat_t st,
    output c39_pkg::c39_cmd_t      cmd,
    output logic                   in_ready
);

    c39_pkg::ctrl_state_t state_reg;
    c39_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c39_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            c39_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_row_end)
                    begin
                        state_next = c39_pkg::ST_CHECK;
                    end
                end
            end
            c39_pkg::ST_CHECK:
            begin
                if (st.row_ovf || st.row_few || st.row_uniform)
                begin
                    cmd.err_latch = 1'b1;
                    cmd.clr_row   = 1'b1;
                    cmd.err_code  = st.row_ovf ? c39_pkg::STS_OVERFLOW :
                                    st.row_few ? c39_pkg::STS_FEW : c39_pkg::STS_UNIFORM;
                    state_next    = c39_pkg::ST_ERR;
                end
                else
                begin
                    cmd.init   = 1'b1;
                    state_next = c39_pkg::ST_START;
                end
            end
            c39_pkg::ST_START:
            begin
                cmd.gather_go = 1'b1;
                state_next    = c39_pkg::ST_START_WAIT;
            end
            c39_pkg::ST_START_WAIT:
            begin
                if (st.gather_done)
                begin
                    if (!st.pat_stop)
                    begin
                        cmd.err_latch = 1'b1;
                        cmd.clr_row   = 1'b1;
                        cmd.err_code  = c39_pkg::STS_BAD_START;
                        state_next    = c39_pkg::ST_ERR;
                    end
                    else
                    begin
                        cmd.pos_add9 = 1'b1;
                        state_next   = c39_pkg::ST_NEXT;
                    end
                end
            end
            c39_pkg::ST_NEXT:
            begin
                if (st.rem9 && st.tlen_zero)
                begin
                    cmd.err_latch = 1'b1;
                    cmd.clr_row   = 1'b1;
                    cmd.err_code  = c39_pkg::STS_EMPTY;
                    state_next    = c39_pkg::ST_ERR;
                end
                else if (st.rem9)
                begin
                    cmd.gather_go = 1'b1;
                    state_next    = c39_pkg::ST_STOP_WAIT;
                end
                else if (st.rem_lt10)
                begin
                    cmd.err_latch = 1'b1;
                    cmd.clr_row   = 1'b1;
                    cmd.err_code  = c39_pkg::STS_TRUNC;
                    state_next    = c39_pkg::ST_ERR;
                end
                else
                begin
                    cmd.gather_go = 1'b1;
                    cmd.gather10  = 1'b1;
                    state_next    = c39_pkg::ST_DATA_WAIT;
                end
            end
            c39_pkg::ST_STOP_WAIT:
            begin
                if (st.gather_done)
                begin
                    cmd.clr_row = 1'b1;
                    if (st.pat_stop)
                    begin
                        cmd.optr_clr = 1'b1;
                        state_next   = c39_pkg::ST_TXT_RD;
                    end
                    else
                    begin
                        cmd.err_latch = 1'b1;
                        cmd.err_code  = c39_pkg::STS_TRUNC;
                        state_next    = c39_pkg::ST_ERR;
                    end
                end
            end
            c39_pkg::ST_DATA_WAIT:
            begin
                if (st.gather_done)
                begin
                    if (st.sep_wide)
                    begin
                        cmd.err_latch = 1'b1;
                        cmd.clr_row   = 1'b1;
                        cmd.err_code  = c39_pkg::STS_WIDE_SEP;
                        state_next    = c39_pkg::ST_ERR;
                    end
                    else if (st.pat_stop && !st.tlen_zero)
                    begin
                        cmd.clr_row  = 1'b1;
                        cmd.optr_clr = 1'b1;
                        state_next   = c39_pkg::ST_TXT_RD;
                    end
                    else if (st.pat_stop || st.pat_miss || st.tlen_full)
                    begin
                        cmd.err_latch = 1'b1;
                        cmd.clr_row   = 1'b1;
                        cmd.err_code  = st.pat_stop ? c39_pkg::STS_EMPTY :
                                        st.pat_miss ? c39_pkg::STS_UNKNOWN :
                                                      c39_pkg::STS_TOO_LONG;
                        state_next    = c39_pkg::ST_ERR;
                    end
                    else
                    begin
                        cmd.txt_wr    = 1'b1;
                        cmd.pos_add10 = 1'b1;
                        state_next    = c39_pkg::ST_NEXT;
                    end
                end
            end
            c39_pkg::ST_ERR:
            begin
                if (st.out_free)
                begin
                    cmd.out_err = 1'b1;
                    state_next  = c39_pkg::ST_LOAD;
                end
            end
            c39_pkg::ST_TXT_RD:
            begin
                state_next = c39_pkg::ST_TXT_OUT;
            end
            c39_pkg::ST_TXT_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_txt = 1'b1;
                    state_next  = st.txt_last ? c39_pkg::ST_LOAD : c39_pkg::ST_TXT_RD;
                end
            end
            default:
            begin
                state_next = c39_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/c39_dp.sv
`default_nettype none

module c39_dp #(
    parameter int RUN_DEPTH = 512,
    parameter int TEXT_MAX  = 32,
    parameter int RUN_BITS  = 12
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire c39_pkg::c39_cmd_t  cmd,
    input  wire logic [11:0]        in_run_width,
    input  wire logic               out_ready,
    output c39_pkg::c39_stat_t      st,
    output logic                    out_valid,
    output c39_pkg::out_item_t      out_data
);

    localparam int CNT_W = $clog2(RUN_DEPTH + 1);
    localparam int AW    = $clog2(RUN_DEPTH);
    localparam int TL_W  = $clog2(TEXT_MAX + 1);
    localparam int TAW   = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
    localparam int IW    = (RUN_BITS < 12) ? RUN_BITS : 12;

    logic [RUN_BITS-1:0] run_mem [RUN_DEPTH];
    logic [6:0]          text_mem [TEXT_MAX];

    logic [CNT_W-1:0]    count_reg;
    logic [RUN_BITS-1:0] min_reg;
    logic [RUN_BITS-1:0] max_reg;
    logic                ovf_reg;
    logic [RUN_BITS-1:0] thr_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    rptr_reg;
    logic [3:0]          issue_reg;
    logic [3:0]          recv_reg;
    logic [3:0]          glen_reg;
    logic                dv_reg;
    logic [RUN_BITS-1:0] q_reg;
    logic [9:0]          pat_reg;
    logic [TL_W-1:0]     tlen_reg;
    logic [TL_W-1:0]     optr_reg;
    logic [6:0]          text_q_reg;
    logic [3:0]          err_reg;
    logic                out_valid_reg;
    c39_pkg::out_item_t  out_data_reg;

    logic [RUN_BITS-1:0] w_in;
    logic [RUN_BITS:0]   sum_w;
    logic [CNT_W-1:0]    rem_w;
    logic [6:0]          char_w;
    logic                issuing;

    assign w_in    = RUN_BITS'(in_run_width[IW-1:0]);
    assign sum_w   = {1'b0, min_reg} + {1'b0, max_reg};
    assign rem_w   = count_reg - pos_reg;
    assign char_w  = c39_pkg::lookup(pat_reg[8:0]);
    assign issuing = (issue_reg != glen_reg);

    // Run store and text store; read data is always registered.
    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < CNT_W'(RUN_DEPTH)))
        begin
            run_mem[count_reg[AW-1:0]] <= w_in;
        end
        q_reg <= run_mem[rptr_reg[AW-1:0]];
        if (cmd.txt_wr)
        begin
            text_mem[tlen_reg[TAW-1:0]] <= char_w;
        end
        text_q_reg <= text_mem[optr_reg[TAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.clr_row)
        begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (count_reg < CNT_W'(RUN_DEPTH))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
            if (w_in < min_reg)
            begin
                min_reg <= w_in;
            end
            if (w_in > max_reg)
            begin
                max_reg <= w_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            thr_reg <= sum_w[RUN_BITS:1];
        end
        if (cmd.err_latch)
        begin
            err_reg <= cmd.err_code;
        end
        if (dv_reg)
        begin
            pat_reg <= {pat_reg[8:0], (q_reg > thr_reg)};
        end
    end

    // Gather unit: reads glen runs from pos and shifts their wide/narrow bits in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            rptr_reg  <= '0;
            issue_reg <= '0;
            recv_reg  <= '0;
            glen_reg  <= '0;
            dv_reg    <= 1'b0;
            tlen_reg  <= '0;
            optr_reg  <= '0;
        end
        else
        begin
            if (cmd.init)
            begin
                pos_reg  <= '0;
                tlen_reg <= '0;
            end
            else if (cmd.pos_add9)
            begin
                pos_reg <= pos_reg + CNT_W'(9);
            end
            else if (cmd.pos_add10)
            begin
                pos_reg <= pos_reg + CNT_W'(10);
            end
            if (cmd.txt_wr)
            begin
                tlen_reg <= tlen_reg + 1'b1;
            end
            if (cmd.gather_go)
            begin
                rptr_reg  <= pos_reg;
                issue_reg <= '0;
                recv_reg  <= '0;
                glen_reg  <= cmd.gather10 ? 4'd10 : 4'd9;
                dv_reg    <= 1'b0;
            end
            else
            begin
                dv_reg <= issuing;
                if (issuing)
                begin
                    rptr_reg  <= rptr_reg + 1'b1;
                    issue_reg <= issue_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    recv_reg <= recv_reg + 1'b1;
                end
            end
            if (cmd.optr_clr)
            begin
                optr_reg <= '0;
            end
            else if (cmd.out_txt)
            begin
                optr_reg <= optr_reg + 1'b1;
            end
        end
    end

    // Output register; a new result may load in the cycle the old one leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_err || cmd.out_txt)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_err)
        begin
            out_data_reg.char_code <= 7'd0;
            out_data_reg.status    <= err_reg;
            out_data_reg.last      <= 1'b1;
        end
        else if (cmd.out_txt)
        begin
            out_data_reg.char_code <= text_q_reg;
            out_data_reg.status    <= c39_pkg::STS_OK;
            out_data_reg.last      <= st.txt_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        st.row_ovf     = ovf_reg;
        st.row_few     = (count_reg < CNT_W'(c39_pkg::MIN_RUNS));
        st.row_uniform = (min_reg == max_reg);
        st.rem9        = (rem_w == CNT_W'(9));
        st.rem_lt10    = (rem_w < CNT_W'(10));
        st.gather_done = (recv_reg == glen_reg) && !issuing && !dv_reg;
        st.sep_wide    = pat_reg[9];
        st.pat_stop    = (pat_reg[8:0] == c39_pkg::STAR_PAT);
        st.pat_miss    = (char_w == 7'd0);
        st.tlen_zero   = (tlen_reg == '0);
        st.tlen_full   = (tlen_reg == TL_W'(TEXT_MAX));
        st.txt_last    = ((optr_reg + 1'b1) == tlen_reg);
        st.out_free    = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

>>> rtl/core/code39_run_decoder_top.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    c39_pkg::in_item_t  (run_width, row_end)
// result    out        out_valid / out_ready  c39_pkg::out_item_t (char_code, status, last)
//
// Each run is taken as soon as it is offered while the block is loading a row.
// After the run flagged row_end, decoding walks the run store at one read a
// cycle, one group of runs at a time; each emitted character then passes a
// text-store read state and an output state that waits for room in the output
// register; a failure emits one result. The group gather unit reads the run store.
// Reset is asynchronous and active low; the run and text stores need no clearing.
// A stalled result sits in the output register; the block stops only when a
// second result is ready, and takes new runs while the last result still waits.

`default_nettype none

module code39_run_decoder_top #(
    parameter int RUN_DEPTH = 512,
    parameter int TEXT_MAX  = 32,
    parameter int RUN_BITS  = 12
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire c39_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output c39_pkg::out_item_t      out_data
);

    // Commands from the sequencer to the datapath, and datapath status back.
    c39_pkg::c39_cmd_t  cmd;
    c39_pkg::c39_stat_t st;

    // The sequencer steps through loading, row checks, start group, data
    // groups, stop group and result emission.
    c39_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_row_end (in_data.row_end),
        .st         (st),
        .cmd        (cmd),
        .in_ready   (in_ready)
    );

    // The datapath holds the run store, width tracking, threshold, the group
    // gather unit, the text store and the output register.
    c39_dp #(
        .RUN_DEPTH (RUN_DEPTH),
        .TEXT_MAX  (TEXT_MAX),
        .RUN_BITS  (RUN_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_run_width (in_data.run_width),
        .out_ready    (out_ready),
        .st           (st),
        .out_valid    (out_valid),
        .out_data     (out_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/c39_checker.sv
`default_nettype none

module c39_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire c39_pkg::in_item_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire c39_pkg::out_item_t out_data
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A failure is a single result with no character.
    a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != c39_pkg::STS_OK)
        |-> out_data.last && (out_data.char_code == 7'd0))
        else $error("failure result malformed");

    // A decoded character is never zero.
    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == c39_pkg::STS_OK) |-> (out_data.char_code != 7'd0))
        else $error("ok result with empty character");

    // The end of a row stops intake while it is decoded.
    a_row_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.row_end |=> !in_ready)
        else $error("input taken during decode");

endmodule

bind code39_run_decoder_top c39_checker u_c39_checker (.*);

`default_nettype wire

>>> sim/tb_code39_run_decoder_top.sv
`timescale 1ns / 100ps

// Testbench for the Code 39 run decoder.
//
// Scan rows are built as streams of bar and space widths and are pushed into a
// feed queue. A sender process offers one run per request, and a receiver
// process takes result requests. Every accepted run is also passed to a
// behavioral decoder kept inside this bench. When a run that closes a row is
// accepted, the expected characters or the failure code are queued, and each
// result request from the block is checked against the oldest entry.
module tb_code39_run_decoder_top;

    // Sizes of the block as built with its default parameters.
    localparam int RUN_CAP  = 512;
    localparam int TEXT_CAP = 32;
    // Table position of the '*' start and stop symbol. Data symbols sit below it.
    localparam int STAR_IDX = 43;

    // Kinds of scan row that the bench can build.
    typedef enum int {
        ROW_TEXT,
        ROW_FEW,
        ROW_UNIFORM,
        ROW_BAD_START,
        ROW_WIDE_SEP,
        ROW_UNKNOWN,
        ROW_CUT,
        ROW_BAD_STOP,
        ROW_OVERFLOW,
        ROW_NOISE
    } row_kind_t;

    // One row of the stimulus table. The variant selects the stop style of a
    // text row (separator and stop, bare stop, or stop followed by junk) and
    // the element pattern of a row with an unknown symbol. When typed is set,
    // sts is the failure code written in by hand for that row.
    typedef struct {
        row_kind_t  kind;
        int         nchar;
        int         variant;
        int         narrow;
        int         wide;
        bit         typed;
        logic [3:0] sts;
    } row_spec_t;

    // One run request waiting in the feed, with the hand-written answer that
    // goes with it when it closes a typed row.
    typedef struct {
        c39_pkg::in_item_t item;
        bit                typed;
        logic [3:0]        sts;
    } run_req_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    c39_pkg::in_item_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    c39_pkg::out_item_t out_data;

    // Stimulus feed and the results that are still owed by the block.
    run_req_t           run_feed[$];
    c39_pkg::out_item_t due_results[$];
    int unsigned        row_w[$];
    int                 runs_queued = 0;
    int                 runs_taken  = 0;
    int                 mismatches  = 0;

    // Width settings of the row being built.
    int unsigned cur_n;
    int unsigned cur_w;
    int unsigned cur_j;
    bit          walk_syms  = 1'b1;
    int          sym_cursor = 0;

    // Idle percentages of both sides and the long receiver hold-off.
    int          tx_idle_pct = 31;
    int          rx_idle_pct = 77;
    bit          hold_go     = 1'b0;
    logic        hold_off    = 1'b0;

    // State of the behavioral decoder.
    logic [11:0] run_mem[RUN_CAP];
    int          run_cnt   = 0;
    logic [11:0] min_w     = '1;
    logic [11:0] max_w     = '0;
    bit          over_seen = 1'b0;
    logic [6:0]  row_text[$];

    // Sender-side copies of the request on the input port.
    run_req_t           next_req;
    bit                 cur_typed = 1'b0;
    logic [3:0]         cur_sts   = c39_pkg::STS_OK;
    c39_pkg::out_item_t want;

    row_spec_t   plan[17];

    code39_run_decoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The Code 39 symbol set as {nine-element wide/narrow pattern, ASCII}.
    // The first element of a group is the top bit of the pattern.
    function automatic logic [15:0] sym_row(input int idx);
        logic [15:0] e;
        case (idx)
            0:  e = {9'h034, 7'h30};  1:  e = {9'h121, 7'h31};  2:  e = {9'h061, 7'h32};
            3:  e = {9'h160, 7'h33};  4:  e = {9'h031, 7'h34};  5:  e = {9'h130, 7'h35};
            6:  e = {9'h070, 7'h36};  7:  e = {9'h025, 7'h37};  8:  e = {9'h124, 7'h38};
            9:  e = {9'h064, 7'h39};  10: e = {9'h109, 7'h41};  11: e = {9'h049, 7'h42};
            12: e = {9'h148, 7'h43};  13: e = {9'h019, 7'h44};  14: e = {9'h118, 7'h45};
            15: e = {9'h058, 7'h46};  16: e = {9'h00D, 7'h47};  17: e = {9'h10C, 7'h48};
            18: e = {9'h04C, 7'h49};  19: e = {9'h01C, 7'h4A};  20: e = {9'h103, 7'h4B};
            21: e = {9'h043, 7'h4C};  22: e = {9'h142, 7'h4D};  23: e = {9'h013, 7'h4E};
            24: e = {9'h112, 7'h4F};  25: e = {9'h052, 7'h50};  26: e = {9'h007, 7'h51};
            27: e = {9'h106, 7'h52};  28: e = {9'h046, 7'h53};  29: e = {9'h016, 7'h54};
            30: e = {9'h181, 7'h55};  31: e = {9'h0C1, 7'h56};  32: e = {9'h1C0, 7'h57};
            33: e = {9'h091, 7'h58};  34: e = {9'h190, 7'h59};  35: e = {9'h0D0, 7'h5A};
            36: e = {9'h085, 7'h2D};  37: e = {9'h184, 7'h2E};  38: e = {9'h0C4, 7'h20};
            39: e = {9'h0A8, 7'h24};  40: e = {9'h0A2, 7'h2F};  41: e = {9'h08A, 7'h2B};
            42: e = {9'h082, 7'h25};  default: e = {9'h094, 7'h2A};
        endcase
        return e;
    endfunction

    // ASCII code of a pattern, or zero when the pattern is not a symbol.
    function automatic logic [6:0] char_of(input logic [8:0] pat);
        logic [15:0] e;
        for (int i = 0; i <= STAR_IDX; i++)
        begin
            e = sym_row(i);
            if (e[15:7] == pat)
                return e[6:0];
        end
        return 7'h00;
    endfunction

    // Classifies nine stored runs from position at against the threshold.
    function automatic logic [8:0] group_at(input int at, input int thr);
        logic [8:0] p;
        p = '0;
        for (int k = 0; k < 9; k++)
            p = {p[7:0], int'(run_mem[at + k]) > thr};
        return p;
    endfunction

    // Decodes the stored row. The status checks follow a fixed order:
    // overflow, short row, uniform widths, start symbol, then the group walk.
    task automatic decode_row(output logic [3:0] code);
        int         thr;
        int         idx;
        int         left;
        bit         busy;
        logic [8:0] pat;
        logic [6:0] c;
        row_text.delete();
        code = c39_pkg::STS_OK;
        thr  = (int'(min_w) + int'(max_w)) >> 1;
        if (over_seen)
            code = c39_pkg::STS_OVERFLOW;
        else if (run_cnt < c39_pkg::MIN_RUNS)
            code = c39_pkg::STS_FEW;
        else if (min_w == max_w)
            code = c39_pkg::STS_UNIFORM;
        else if (group_at(0, thr) != c39_pkg::STAR_PAT)
            code = c39_pkg::STS_BAD_START;
        else
        begin
            idx  = 9;
            busy = 1'b1;
            while (busy)
            begin
                busy = 1'b0;
                left = run_cnt - idx;
                if (left == 9)
                begin
                    // A bare stop symbol with no separator in front of it.
                    if (row_text.size() == 0)
                        code = c39_pkg::STS_EMPTY;
                    else if (group_at(idx, thr) != c39_pkg::STAR_PAT)
                        code = c39_pkg::STS_TRUNC;
                end
                else if (left < 10)
                    code = c39_pkg::STS_TRUNC;
                else if (int'(run_mem[idx]) > thr)
                    code = c39_pkg::STS_WIDE_SEP;
                else
                begin
                    pat = group_at(idx + 1, thr);
                    if (pat == c39_pkg::STAR_PAT)
                    begin
                        // Anything stored after the stop symbol is ignored.
                        if (row_text.size() == 0)
                            code = c39_pkg::STS_EMPTY;
                    end
                    else
                    begin
                        c = char_of(pat);
                        if (c == 7'h00)
                            code = c39_pkg::STS_UNKNOWN;
                        else if (row_text.size() >= TEXT_CAP)
                            code = c39_pkg::STS_TOO_LONG;
                        else
                        begin
                            row_text.push_back(c);
                            idx += 10;
                            busy = 1'b1;
                        end
                    end
                end
            end
        end
    endtask

    // Takes one accepted run into the decoder state. A run that closes the
    // row triggers the decode, queues the owed results and clears the row.
    task automatic take_run(input c39_pkg::in_item_t it, input bit typed,
                            input logic [3:0] sts);
        logic [3:0]         code;
        c39_pkg::out_item_t res;
        if (run_cnt < RUN_CAP)
        begin
            run_mem[run_cnt] = it.run_width;
            run_cnt++;
        end
        else
            over_seen = 1'b1;
        if (it.run_width < min_w)
            min_w = it.run_width;
        if (it.run_width > max_w)
            max_w = it.run_width;
        if (it.row_end)
        begin
            decode_row(code);
            run_cnt   = 0;
            min_w     = '1;
            max_w     = '0;
            over_seen = 1'b0;
            if (typed || code != c39_pkg::STS_OK)
            begin
                res.char_code = 7'h00;
                res.status    = typed ? sts : code;
                res.last      = 1'b1;
                due_results.push_back(res);
            end
            else
                for (int k = 0; k < row_text.size(); k++)
                begin
                    res.char_code = row_text[k];
                    res.status    = c39_pkg::STS_OK;
                    res.last      = (k == row_text.size() - 1);
                    due_results.push_back(res);
                end
        end
    endtask

    // Row building: elements are narrow or wide with a little jitter toward
    // the threshold, kept small enough that the classification holds.
    task automatic add_raw(input int unsigned width);
        row_w.push_back(width);
    endtask

    task automatic add_elem(input bit wide);
        if (wide)
            row_w.push_back(cur_w - $urandom_range(cur_j));
        else
            row_w.push_back(cur_n + $urandom_range(cur_j));
    endtask

    task automatic add_group(input logic [8:0] pat);
        for (int k = 8; k >= 0; k--)
            add_elem(pat[k]);
    endtask

    // Adds one data symbol: the table in order for the directed rows so that
    // every symbol shows up, a random one afterwards.
    task automatic add_char();
        logic [15:0] e;
        int          idx;
        if (walk_syms)
        begin
            idx        = sym_cursor;
            sym_cursor = (sym_cursor + 1) % STAR_IDX;
        end
        else
            idx = $urandom_range(STAR_IDX - 1);
        e = sym_row(idx);
        add_group(e[15:7]);
    endtask

    // Moves the built row into the feed, with row_end on its final run.
    task automatic close_row(input bit typed, input logic [3:0] sts);
        run_req_t r;
        for (int i = 0; i < row_w.size(); i++)
        begin
            r.item.run_width = 12'(row_w[i]);
            r.item.row_end   = (i == row_w.size() - 1);
            r.typed          = typed && r.item.row_end;
            r.sts            = sts;
            run_feed.push_back(r);
        end
        runs_queued += row_w.size();
        row_w.delete();
    endtask

    task automatic build_row(input row_spec_t s, input int unsigned jit);
        int k;
        cur_n = s.narrow;
        cur_w = s.wide;
        cur_j = jit;
        case (s.kind)
            ROW_TEXT:
            begin
                add_group(c39_pkg::STAR_PAT);
                for (k = 0; k < s.nchar; k++)
                begin
                    add_elem(1'b0);
                    add_char();
                end
                if (s.variant != 1)
                    add_elem(1'b0);
                add_group(c39_pkg::STAR_PAT);
                if (s.variant == 2)
                    for (k = $urandom_range(12, 1); k > 0; k--)
                        add_elem(k[0]);
            end
            ROW_FEW:
                for (k = 0; k < s.nchar; k++)
                    add_elem(k[0]);
            ROW_UNIFORM:
                for (k = 0; k < 29; k++)
                    add_raw(s.narrow);
            ROW_BAD_START:
            begin
                add_char();
                add_elem(1'b0);
                add_char();
                add_elem(1'b0);
                add_group(c39_pkg::STAR_PAT);
            end
            ROW_WIDE_SEP:
            begin
                add_group(c39_pkg::STAR_PAT);
                add_elem(1'b1);
                add_char();
                add_elem(1'b0);
                add_group(c39_pkg::STAR_PAT);
            end
            ROW_UNKNOWN:
            begin
                add_group(c39_pkg::STAR_PAT);
                add_elem(1'b0);
                add_group(9'(s.variant));
                add_elem(1'b0);
                add_group(c39_pkg::STAR_PAT);
            end
            ROW_CUT:
            begin
                add_group(c39_pkg::STAR_PAT);
                add_elem(1'b0);
                add_char();
                for (k = 0; k < s.nchar; k++)
                    add_elem(1'b0);
            end
            ROW_BAD_STOP:
            begin
                // A data symbol sits where the stop symbol belongs.
                add_group(c39_pkg::STAR_PAT);
                add_elem(1'b0);
                add_char();
                add_char();
            end
            ROW_OVERFLOW:
                for (k = 0; k < RUN_CAP + 3; k++)
                    add_elem(k[0]);
            default:
                for (k = 0; k < s.nchar; k++)
                    add_raw($urandom_range(4095));
        endcase
        close_row(s.typed, s.sts);
    endtask

    // Random rows: mostly well-formed text with random widths and content,
    // the rest noise and rows broken in one of the ways the decoder reports.
    task automatic random_rows(input int count);
        row_spec_t s;
        int        pick;
        for (int i = 0; i < count; i++)
        begin
            s.narrow  = $urandom_range(1300);
            s.wide    = 2 * s.narrow + 1 + $urandom_range(4094 - 2 * s.narrow);
            s.typed   = 1'b0;
            s.sts     = c39_pkg::STS_OK;
            s.variant = $urandom_range(2);
            s.nchar   = ($urandom_range(7) == 0) ? $urandom_range(33, 6) : $urandom_range(5);
            s.kind    = ROW_TEXT;
            pick      = $urandom_range(99);
            if (pick >= 65 && pick < 75)
            begin
                s.kind  = ROW_NOISE;
                s.nchar = $urandom_range(60, 1);
            end
            else if (pick >= 75 && pick < 98)
                case ($urandom_range(6))
                    0:
                    begin
                        s.kind  = ROW_FEW;
                        s.nchar = $urandom_range(18, 1);
                    end
                    1: s.kind = ROW_UNIFORM;
                    2: s.kind = ROW_BAD_START;
                    3: s.kind = ROW_WIDE_SEP;
                    4:
                    begin
                        s.kind    = ROW_UNKNOWN;
                        s.variant = $urandom_range(511);
                    end
                    5:
                    begin
                        s.kind  = ROW_CUT;
                        s.nchar = $urandom_range(9, 1);
                    end
                    default: s.kind = ROW_BAD_STOP;
                endcase
            else if (pick >= 98)
                s.kind = ROW_OVERFLOW;
            build_row(s, $urandom_range((s.wide - s.narrow) / 4));
        end
    endtask

    // Sender. A new run is offered only once the previous request has been
    // taken, and it may be held back at random. The accepted run
    // is handed to the decoder model at the edge where the request completes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                take_run(in_data, cur_typed, cur_sts);
                runs_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (run_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    next_req  = run_feed.pop_front();
                    in_data   <= next_req.item;
                    cur_typed <= next_req.typed;
                    cur_sts   <= next_req.sts;
                    in_valid  <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver. Ready drops at random, and stays low for the whole hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
    end

    // The hold-off keeps result requests blocked long enough for the block to
    // fill its output stage and push back on the run stream.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (2000) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Each result request is compared with the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result char %h status %0d last %0d",
                         $time, out_data.char_code, out_data.status, out_data.last);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                if (out_data.char_code !== want.char_code)
                begin
                    $display("%0t: char_code expected %h got %h",
                             $time, want.char_code, out_data.char_code);
                    mismatches++;
                end
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, out_data.status);
                    mismatches++;
                end
                if (out_data.last !== want.last)
                begin
                    $display("%0t: last expected %0d got %0d",
                             $time, want.last, out_data.last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4000000;
        $display("[code39_run_decoder_top] ERROR");
        $finish;
    end

    initial
    begin
        row_spec_t burst;

        // Directed rows. Failure rows whose code is plain from their layout
        // carry it typed in; the others are checked by the decoder model.
        plan[0]  = '{ROW_FEW,       1,  0, 5,    40,   1'b1, c39_pkg::STS_FEW};
        plan[1]  = '{ROW_FEW,       18, 0, 5,    40,   1'b1, c39_pkg::STS_FEW};
        plan[2]  = '{ROW_UNIFORM,   0,  0, 4095, 4095, 1'b1, c39_pkg::STS_UNIFORM};
        plan[3]  = '{ROW_TEXT,      1,  0, 0,    4095, 1'b0, c39_pkg::STS_OK};
        plan[4]  = '{ROW_TEXT,      16, 1, 1,    3,    1'b0, c39_pkg::STS_OK};
        plan[5]  = '{ROW_TEXT,      32, 2, 200,  600,  1'b0, c39_pkg::STS_OK};
        plan[6]  = '{ROW_TEXT,      33, 0, 10,   30,   1'b1, c39_pkg::STS_TOO_LONG};
        plan[7]  = '{ROW_TEXT,      0,  0, 10,   30,   1'b1, c39_pkg::STS_EMPTY};
        plan[8]  = '{ROW_TEXT,      0,  1, 10,   30,   1'b0, c39_pkg::STS_OK};
        plan[9]  = '{ROW_BAD_START, 0,  0, 10,   30,   1'b1, c39_pkg::STS_BAD_START};
        plan[10] = '{ROW_WIDE_SEP,  0,  0, 10,   30,   1'b1, c39_pkg::STS_WIDE_SEP};
        plan[11] = '{ROW_UNKNOWN,   0,  0, 10,   30,   1'b1, c39_pkg::STS_UNKNOWN};
        plan[12] = '{ROW_CUT,       5,  0, 10,   30,   1'b1, c39_pkg::STS_TRUNC};
        plan[13] = '{ROW_BAD_STOP,  0,  0, 10,   30,   1'b1, c39_pkg::STS_TRUNC};
        plan[14] = '{ROW_OVERFLOW,  0,  0, 7,    90,   1'b1, c39_pkg::STS_OVERFLOW};
        plan[15] = '{ROW_NOISE,     40, 0, 0,    0,    1'b0, c39_pkg::STS_OK};
        plan[16] = '{ROW_TEXT,      3,  2, 2047, 4095, 1'b0, c39_pkg::STS_OK};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sender mostly busy, receiver mostly idle.
        for (int i = 0; i < 17; i++)
            build_row(plan[i], 0);
        walk_syms = 1'b0;
        random_rows(7);
        while (runs_taken != runs_queued)
            @(posedge clk);

        // Sender mostly idle, receiver mostly busy.
        tx_idle_pct = 77;
        rx_idle_pct = 31;
        random_rows(7);
        while (runs_taken != runs_queued)
            @(posedge clk);

        // No idling on either side, with the long receiver hold-off at the
        // start while a full-length text row and more rows are offered.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go     = 1'b1;
        burst       = '{ROW_TEXT, 32, 0, 60, 200, 1'b0, c39_pkg::STS_OK};
        build_row(burst, 10);
        random_rows(7);
        while (runs_taken != runs_queued)
            @(posedge clk);

        while (due_results.size() != 0)
            @(posedge clk);
        // Room for a stray result from a long decode pass.
        repeat (1000) @(posedge clk);

        if (mismatches == 0)
            $display("[code39_run_decoder_top] OK");
        else
            $display("[code39_run_decoder_top] ERROR");
        $finish;
    end

endmodule
